>>> src/gap_buffer_text_store_top_macros.svh
// assertion macros for the gap buffer text store
// expects clk and rst in the scope of the module that uses them
`ifndef GAP_BUFFER_TEXT_STORE_TOP_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_TOP_MACROS_SVH

// property that holds at every clock edge out of reset
`define GBTS_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define GBTS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GBTS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/gbts_pkg.sv
// shared types and codes for the gap buffer text store
// no dependencies
package gbts_pkg;

  localparam int TYPE_W   = 2;
  localparam int CHAR_W   = 16;
  localparam int IDX_W    = 13;
  localparam int STATUS_W = 2;

  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_MOVE   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  index_in;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   read_char;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    gap_pos;
    logic [IDX_W-1:0]    content_len;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESP
  } state_t;

endpackage

>>> src/gbts_mem.sv
// single-port character store with registered read data
// no dependencies
module gbts_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> src/gap_buffer_text_store_top.sv
// Gap buffer text store. A request is taken when start is high and busy is low; its single
// result appears on result for exactly one cycle with done high and cannot be held off.
// Insert, read and the unused request type give their result in the cycle after the accepting
// edge; busy stays high while the result is given, so the next request is taken only after it.
// A gap move goes from ST_MOVE_RD to ST_MOVE_WR and back once for each character shifted,
// then from ST_MOVE_RD to ST_RESP for its result, since each character needs one read and
// one write of the single-port store; it too takes the next request only after its result.
// An insert is rejected with full status once only one gap slot is left.
// depends on gbts_pkg, gbts_mem and gap_buffer_text_store_top_macros.svh
`include "gap_buffer_text_store_top_macros.svh"

module gap_buffer_text_store_top #(
  parameter int CAPACITY  = 4096,
  parameter int CHAR_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gbts_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output gbts_pkg::rsp_t result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > gbts_pkg::IDX_W) ? PW : gbts_pkg::IDX_W;

  gbts_pkg::state_t state, state_next;

  logic [PW-1:0] front, front_next;
  logic [PW-1:0] gap_length, gap_next;
  logic [PW-1:0] target, target_next;
  logic          dir_back, dir_next;
  logic [gbts_pkg::STATUS_W-1:0] status_q, status_next;
  logic          rd_ok, rd_ok_next;

  logic          accept;
  logic [PW-1:0] content;
  logic [PW-1:0] front_m1;
  logic [CW-1:0] idx_w, content_w, front_w;

  logic [PW-1:0] add_base;
  logic          add_gap;
  logic [PW-1:0] slot_sum;

  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [CHAR_BITS-1:0] mem_wdata;
  logic [CHAR_BITS-1:0] mem_rdata;

  logic [PW:0]   span;
  logic [PW-1:0] gap_m1;
  logic          ins_take;
  logic          move_wr;

  assign accept    = start && (state == gbts_pkg::ST_IDLE);
  assign content   = PW'(CAPACITY) - gap_length;
  assign front_m1  = front - 1'b1;
  assign idx_w     = CW'(request.index_in);
  assign content_w = CW'(content);
  assign front_w   = CW'(front);

  // shared slot adder
  assign slot_sum = add_base + (add_gap ? gap_length : '0);
  assign mem_addr = slot_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbts_pkg::ST_IDLE;
      front      <= '0;
      gap_length <= PW'(CAPACITY);
      status_q   <= gbts_pkg::STATUS_OK;
      rd_ok      <= 1'b0;
    end else begin
      state      <= state_next;
      front      <= front_next;
      gap_length <= gap_next;
      status_q   <= status_next;
      rd_ok      <= rd_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    target   <= target_next;
    dir_back <= dir_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gbts_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (request.req_type == gbts_pkg::REQ_MOVE) ? gbts_pkg::ST_MOVE_RD
                                                               : gbts_pkg::ST_RESP;
        end
      end
      gbts_pkg::ST_MOVE_RD: begin
        state_next = (front != target) ? gbts_pkg::ST_MOVE_WR : gbts_pkg::ST_RESP;
      end
      gbts_pkg::ST_MOVE_WR: begin
        state_next = gbts_pkg::ST_MOVE_RD;
      end
      gbts_pkg::ST_RESP: begin
        state_next = gbts_pkg::ST_IDLE;
      end
      default: begin
        state_next = gbts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    front_next  = front;
    gap_next    = gap_length;
    target_next = target;
    dir_next    = dir_back;
    status_next = status_q;
    rd_ok_next  = rd_ok;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    add_base    = front;
    add_gap     = 1'b0;
    mem_wdata   = mem_rdata;
    unique case (state)
      gbts_pkg::ST_IDLE: begin
        mem_wdata = CHAR_BITS'(request.char_in);
        if (accept) begin
          status_next = gbts_pkg::STATUS_OK;
          rd_ok_next  = 1'b0;
          unique case (request.req_type)
            gbts_pkg::REQ_INSERT: begin
              if (gap_length <= PW'(1)) begin
                status_next = gbts_pkg::STATUS_FULL;
              end else begin
                mem_we     = 1'b1;
                front_next = front + 1'b1;
                gap_next   = gap_length - 1'b1;
              end
            end
            gbts_pkg::REQ_MOVE: begin
              target_next = (idx_w > content_w) ? content : PW'(request.index_in);
            end
            gbts_pkg::REQ_READ: begin
              if (idx_w >= content_w) begin
                status_next = gbts_pkg::STATUS_RANGE;
              end else begin
                mem_re     = 1'b1;
                add_base   = PW'(request.index_in);
                add_gap    = (idx_w >= front_w);
                rd_ok_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gbts_pkg::ST_MOVE_RD: begin
        if (front < target) begin
          mem_re   = 1'b1;
          add_gap  = 1'b1;
          dir_next = 1'b0;
        end else if (front > target) begin
          mem_re   = 1'b1;
          add_base = front_m1;
          dir_next = 1'b1;
        end
      end
      gbts_pkg::ST_MOVE_WR: begin
        mem_we = 1'b1;
        if (dir_back) begin
          add_base   = front_m1;
          add_gap    = 1'b1;
          front_next = front_m1;
        end else begin
          front_next = front + 1'b1;
        end
      end
      gbts_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  gbts_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(CHAR_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign busy = (state != gbts_pkg::ST_IDLE);
  assign done = (state == gbts_pkg::ST_RESP);

  always_comb begin
    result.read_char   = rd_ok ? gbts_pkg::CHAR_W'(mem_rdata) : '0;
    result.status      = status_q;
    result.gap_pos     = gbts_pkg::IDX_W'(front);
    result.content_len = gbts_pkg::IDX_W'(content);
  end

  assign span     = (PW+1)'(front) + (PW+1)'(gap_length);
  assign gap_m1   = gap_length - 1'b1;
  assign ins_take = accept && (request.req_type == gbts_pkg::REQ_INSERT) && (gap_length > PW'(1));
  assign move_wr  = (state == gbts_pkg::ST_MOVE_WR);

  `GBTS_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
  `GBTS_HOLDS(a_gap_open, gap_length != '0, "gap closed completely")
  `GBTS_HOLDS(a_front_fits, span <= (PW+1)'(CAPACITY), "front run overlaps back run")
  `GBTS_NEXT(a_insert_shrinks_gap, ins_take, gap_length == $past(gap_m1), "insert kept gap length")
  `GBTS_NEXT(a_move_keeps_gap, move_wr, $stable(gap_length), "gap length changed during a move")

endmodule

>>> dv/gap_buffer_text_store_top_tb.sv
// testbench for gap_buffer_text_store_top: insert, gap move, read and unused-type requests checked
// against a gap buffer model kept in the testbench; depends on gbts_pkg and the top level
`timescale 1ns / 100ps

module gap_buffer_text_store_top_tb;

  localparam int STORE_SLOTS = 4096;
  localparam int MAX_TEXT    = STORE_SLOTS - 1;
  localparam int RAND_COUNT  = 1870;
  localparam int STALL_LIMIT = 40000;
  localparam logic [gbts_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  gbts_pkg::req_t request = '0;
  logic busy;
  logic done;
  gbts_pkg::rsp_t result;

  gbts_pkg::req_t pending_requests[$];
  gbts_pkg::rsp_t expected_outcomes[$];

  logic [gbts_pkg::CHAR_W-1:0] text_mem [0:STORE_SLOTS-1];
  int front_len = 0;
  int gap_len = STORE_SLOTS;

  int plan_front = 0;
  int plan_len = 0;

  int idle_left = 0;
  int burst_left = 0;
  int stall_cycles = 0;
  int mismatches = 0;

  gap_buffer_text_store_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic gbts_pkg::rsp_t edit_text_model(gbts_pkg::req_t r);
    gbts_pkg::rsp_t o;
    int target;
    int text_len;
    o = '0;
    text_len = STORE_SLOTS - gap_len;
    case (r.req_type)
      gbts_pkg::REQ_INSERT: begin
        if (gap_len <= 1) begin
          o.status = gbts_pkg::STATUS_FULL;
        end else begin
          text_mem[front_len] = r.char_in;
          front_len++;
          gap_len--;
        end
      end
      gbts_pkg::REQ_MOVE: begin
        target = int'(r.index_in);
        if (target > text_len) target = text_len;
        while (front_len < target) begin
          text_mem[front_len] = text_mem[front_len + gap_len];
          front_len++;
        end
        while (front_len > target) begin
          front_len--;
          text_mem[front_len + gap_len] = text_mem[front_len];
        end
      end
      gbts_pkg::REQ_READ: begin
        if (int'(r.index_in) >= text_len) begin
          o.status = gbts_pkg::STATUS_RANGE;
        end else if (int'(r.index_in) < front_len) begin
          o.read_char = text_mem[r.index_in];
        end else begin
          o.read_char = text_mem[int'(r.index_in) + gap_len];
        end
      end
      default: begin
      end
    endcase
    o.gap_pos = gbts_pkg::IDX_W'(front_len);
    o.content_len = gbts_pkg::IDX_W'(STORE_SLOTS - gap_len);
    return o;
  endfunction

  // plan_front and plan_len track the text shape so random indexes land near it
  task automatic queue_request(logic [gbts_pkg::TYPE_W-1:0] kind,
                               logic [gbts_pkg::CHAR_W-1:0] ch, int idx);
    gbts_pkg::req_t r;
    r.req_type = kind;
    r.char_in = ch;
    r.index_in = gbts_pkg::IDX_W'(idx);
    pending_requests.push_back(r);
    if (kind == gbts_pkg::REQ_INSERT && plan_len < MAX_TEXT) begin
      plan_len++;
      plan_front++;
    end else if (kind == gbts_pkg::REQ_MOVE) begin
      plan_front = (int'(r.index_in) > plan_len) ? plan_len : int'(r.index_in);
    end
  endtask

  function automatic int pick_index();
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      v = plan_front + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
    end else if (k < 8) begin
      v = $urandom_range(0, plan_len);
    end else if (k < 9) begin
      v = plan_len + int'($urandom_range(0, 3));
    end else begin
      v = $urandom_range(0, 8191);
    end
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
      idle_left = 0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_outcomes.push_back(edit_text_model(request));
        if (burst_left > 0) begin
          burst_left--;
          idle_left = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          burst_left = $urandom_range(10, 40);
          idle_left = 0;
        end else begin
          idle_left = $urandom_range(0, 12);
        end
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request <= pending_requests.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    gbts_pkg::rsp_t exp_rsp;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %h", $time, result);
      end else begin
        exp_rsp = expected_outcomes.pop_front();
        if (result.read_char !== exp_rsp.read_char) begin
          mismatches++;
          $display("%0t: read_char expected %h actual %h", $time,
                   exp_rsp.read_char, result.read_char);
        end
        if (result.status !== exp_rsp.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_rsp.status, result.status);
        end
        if (result.gap_pos !== exp_rsp.gap_pos) begin
          mismatches++;
          $display("%0t: gap_pos expected %0d actual %0d", $time,
                   exp_rsp.gap_pos, result.gap_pos);
        end
        if (result.content_len !== exp_rsp.content_len) begin
          mismatches++;
          $display("%0t: content_len expected %0d actual %0d", $time,
                   exp_rsp.content_len, result.content_len);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int sel;
    logic [gbts_pkg::CHAR_W-1:0] ch;

    // empty store
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 8191);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 8191);
    queue_request(REQ_UNUSED, 16'hFFFF, 8191);
    queue_request(gbts_pkg::REQ_INSERT, 16'h0001, 0);
    queue_request(gbts_pkg::REQ_INSERT, 16'hFFFF, 0);
    queue_request(gbts_pkg::REQ_INSERT, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_INSERT, 16'hA5A5, 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 3);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 4);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 1);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 3);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 2);
    queue_request(gbts_pkg::REQ_INSERT, 16'h5A5A, 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 2);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 4);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 4096);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 4096);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 5);
    queue_request(REQ_UNUSED, 16'h0000, 0);

    // mixed traffic
    for (int i = 0; i < RAND_COUNT; i++) begin
      sel = $urandom_range(0, 99);
      ch = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 19) == 0) ch = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      if (sel < 35) queue_request(gbts_pkg::REQ_INSERT, ch, $urandom_range(0, 8191));
      else if (sel < 60) queue_request(gbts_pkg::REQ_MOVE, ch, pick_index());
      else if (sel < 95) queue_request(gbts_pkg::REQ_READ, ch, pick_index());
      else queue_request(REQ_UNUSED, ch, $urandom_range(0, 8191));
    end

    // edits and reads near both ends of the text
    for (int i = 0; i < 3; i++)
      queue_request(gbts_pkg::REQ_INSERT, 16'($urandom_range(0, 65535)), 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, MAX_TEXT - 1);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, MAX_TEXT);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_INSERT, 16'hFFFF, 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, MAX_TEXT - 1);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 8191);
    queue_request(gbts_pkg::REQ_INSERT, 16'h0000, 0);
    queue_request(gbts_pkg::REQ_MOVE, 16'h0000, 2048);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 2047);
    queue_request(gbts_pkg::REQ_READ, 16'h0000, 2048);
    queue_request(REQ_UNUSED, 16'hFFFF, 8191);
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 3) == 0) queue_request(gbts_pkg::REQ_MOVE, 16'h0000, pick_index());
      else queue_request(gbts_pkg::REQ_READ, 16'h0000, pick_index());
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/gbts_pkg.sv
src/gbts_mem.sv
src/gap_buffer_text_store_top.sv
dv/gap_buffer_text_store_top_tb.sv
